// ----- sv/fcc_pkg.sv -----
// ----------------------------------------------------------------------------
// Frustum cull classify package
// Shared types, widths, stream field offsets and the signed multiply helper.
// ----------------------------------------------------------------------------
package fcc_pkg;

  // Number of frustum planes tested by default.
  localparam int unsigned NUM_PLANES_DEF = 6;

  // Pipeline depth: product, sum, extent product, plane test, output.
  localparam int unsigned NUM_STAGES = 5;

  localparam int unsigned COEF_W  = 16;  // one Q1.14 or Q11.4 word
  localparam int unsigned EXT_W   = 15;  // radius and half lengths
  localparam int unsigned OP_W    = 2;
  localparam int unsigned PROD_W  = 2 * COEF_W;
  localparam int unsigned DIST_W  = 34;  // center distance, 18 fraction bits
  localparam int unsigned NABS_W  = 32;  // |n . axis|, fits since 3 * 2^30 < 2^32
  localparam int unsigned HP_W    = NABS_W + EXT_W;
  localparam int unsigned HALF_W  = HP_W + 2;
  localparam int unsigned SPH_W   = DIST_W + 1;
  localparam int unsigned CMP_W   = HALF_W + 2;
  localparam int unsigned FRAC_SH = 14;  // aligns Q11.4 or Q1.14 terms

  // Configuration port.
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 64;

  // Input stream packing, lowest bit first.
  localparam int unsigned POS_LSB     = 0;
  localparam int unsigned RAD_LSB     = 48;
  localparam int unsigned AXIS_LSB    = 63;
  localparam int unsigned AXIS_W      = 3 * COEF_W;
  localparam int unsigned EXT_LSB     = AXIS_LSB + 3 * AXIS_W;
  localparam int unsigned TDATA_IN_W  = 256;
  localparam int unsigned TDATA_OUT_W = 8;

  typedef logic signed [COEF_W-1:0] coef_t;
  typedef coef_t [2:0] vec_t;               // [0] x or a, [1] y or b, [2] z or c

  typedef struct packed {
    coef_t d;
    vec_t  n;
  } plane_t;

  typedef enum logic [OP_W-1:0] {
    OP_POINT  = 2'd0,
    OP_SPHERE = 2'd1,
    OP_BOX    = 2'd2
  } op_e;

  typedef struct packed {
    logic [NUM_STAGES-1:0] en;         // stage k captures its next item
    logic                  out_valid;
  } pipe_ctl_t;

  function automatic logic signed [PROD_W-1:0] smul(coef_t a, coef_t b);
    smul = PROD_W'(a) * PROD_W'(b);
  endfunction

endpackage

// ----- sv/fcc_ctrl.sv -----
// ----------------------------------------------------------------------------
// Frustum cull pipeline control
// Per-stage valid bits and stage enables; a stage moves when it is empty or
// when the stage after it moves, so bubbles collapse under back pressure.
// ----------------------------------------------------------------------------
module fcc_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_valid_i,
  input  logic               m_ready_i,
  output fcc_pkg::pipe_ctl_t ctl_o
);
  import fcc_pkg::*;

  logic [NUM_STAGES-1:0] valid_q, valid_d;
  logic [NUM_STAGES-1:0] en;

  always_comb begin
    en[NUM_STAGES-1] = !valid_q[NUM_STAGES-1] || m_ready_i;
    for (int k = NUM_STAGES - 2; k >= 0; k--) begin
      en[k] = !valid_q[k] || en[k+1];
    end
    valid_d = valid_q;
    if (en[0]) begin
      valid_d[0] = s_valid_i;
    end
    for (int k = 1; k < NUM_STAGES; k++) begin
      if (en[k]) begin
        valid_d[k] = valid_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign ctl_o.en        = en;
  assign ctl_o.out_valid = valid_q[NUM_STAGES-1];

endmodule

// ----- sv/fcc_lane.sv -----
// ----------------------------------------------------------------------------
// Frustum cull plane lane
// Tests the item against one plane over four register stages and reports
// whether that plane rejects it.
// ----------------------------------------------------------------------------
module fcc_lane (
  input  logic                              clk_i,
  input  fcc_pkg::pipe_ctl_t                ctl_i,
  input  fcc_pkg::plane_t                   plane_i,
  input  fcc_pkg::vec_t                     pos_i,    // live input item
  input  fcc_pkg::vec_t [2:0]               axes_i,   // live input item
  input  logic [2:0][fcc_pkg::EXT_W-1:0]    ext_i,    // item in stage two
  input  logic [fcc_pkg::EXT_W-1:0]         rad_i,    // item in stage three
  input  fcc_pkg::op_e                      op_i,     // item in stage three
  output logic                              reject_o
);
  import fcc_pkg::*;

  // Stage one: products.
  logic signed [PROD_W-1:0] pd_q [3];
  logic signed [PROD_W-1:0] pn_q [3][3];

  always_ff @(posedge clk_i) begin
    if (ctl_i.en[0]) begin
      for (int j = 0; j < 3; j++) begin
        pd_q[j] <= smul(plane_i.n[j], pos_i[j]);
        for (int k = 0; k < 3; k++) begin
          pn_q[k][j] <= smul(plane_i.n[j], axes_i[k][j]);
        end
      end
    end
  end

  // Stage two: center distance and |n . axis|.
  logic signed [DIST_W-1:0] nsum [3];
  logic signed [DIST_W-1:0] dist_q;
  logic [NABS_W-1:0]        nabs_q [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      nsum[k] = DIST_W'(pn_q[k][0]) + DIST_W'(pn_q[k][1]) + DIST_W'(pn_q[k][2]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en[1]) begin
      dist_q <= DIST_W'(pd_q[0]) + DIST_W'(pd_q[1]) + DIST_W'(pd_q[2]) +
                (DIST_W'(plane_i.d) <<< FRAC_SH);
      for (int k = 0; k < 3; k++) begin
        nabs_q[k] <= nsum[k][DIST_W-1] ? NABS_W'(-nsum[k]) : NABS_W'(nsum[k]);
      end
    end
  end

  // Stage three: projected half size terms.
  logic signed [DIST_W-1:0] dist3_q;
  logic [HP_W-1:0]          hp_q [3];

  always_ff @(posedge clk_i) begin
    if (ctl_i.en[2]) begin
      dist3_q <= dist_q;
      for (int k = 0; k < 3; k++) begin
        hp_q[k] <= HP_W'(nabs_q[k]) * HP_W'(ext_i[k]);
      end
    end
  end

  // Stage four: plane test for the selected object kind.
  logic [HALF_W-1:0]       half;
  logic signed [SPH_W-1:0] sph_sum;
  logic signed [CMP_W-1:0] box_sum;
  logic                    reject_d;
  logic                    reject_q;

  always_comb begin
    half    = HALF_W'(hp_q[0]) + HALF_W'(hp_q[1]) + HALF_W'(hp_q[2]);
    sph_sum = SPH_W'(dist3_q) + $signed(SPH_W'(rad_i) << FRAC_SH);
    box_sum = (CMP_W'(dist3_q) <<< FRAC_SH) + $signed(CMP_W'(half));
    case (op_i)
      OP_POINT:  reject_d = dist3_q[DIST_W-1];
      OP_SPHERE: reject_d = sph_sum[SPH_W-1] || (sph_sum == '0);
      OP_BOX:    reject_d = box_sum[CMP_W-1] || (box_sum == '0);
      default:   reject_d = 1'b0;  // the unused kind is never culled
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en[3]) begin
      reject_q <= reject_d;
    end
  end

  assign reject_o = reject_q;

endmodule

// ----- sv/frustum_cull_classify_core.sv -----
// An accepted item passes the product, sum, extent product, plane test and output
// registers to the result. Throughput: one item per cycle unless m_axis_tready
// stalls the output; every stage is a register of its own and the rate is set by
// the five-stage pipeline, which runs all planes at once. Reset clears the valid
// bits and all plane registers to zero; the block accepts items once reset is released.
// ----------------------------------------------------------------------------
// Frustum cull classify core
// Tests a point, sphere or oriented box against the configured frustum planes
// and reports whether it is visible.
// ----------------------------------------------------------------------------
module frustum_cull_classify_core #(
  parameter int unsigned NUM_PLANES = fcc_pkg::NUM_PLANES_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // Configuration write channel.
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [fcc_pkg::CFG_IDX_W-1:0]      cfg_addr_i,
  input  logic [fcc_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  // Input items.
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // pos_x, pos_y, pos_z, radius, axis_one, axis_two, axis_three,
  // extent_one, extent_two, extent_three, then zero fill
  input  logic [fcc_pkg::TDATA_IN_W-1:0]     s_axis_tdata,
  input  logic [fcc_pkg::OP_W-1:0]           s_axis_tuser,  // op
  // Result items.
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [fcc_pkg::TDATA_OUT_W-1:0]    m_axis_tdata   // visible, then zero fill
);
  import fcc_pkg::*;

  // Plane registers.
  plane_t plane_q [NUM_PLANES];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_PLANES; i++) begin
        plane_q[i] <= '0;
      end
    end else if (cfg_valid_i) begin
      for (int i = 0; i < NUM_PLANES; i++) begin
        if (cfg_addr_i == CFG_IDX_W'(i)) begin
          plane_q[i] <= cfg_wdata_i;
        end
      end
    end
  end

  assign cfg_ready_o = 1'b1;

  // Pipeline control.
  pipe_ctl_t ctl;

  fcc_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .ctl_o     (ctl)
  );

  assign s_axis_tready = ctl.en[0];

  // Input unpacking.
  vec_t                  pos_in;
  vec_t [2:0]            axes_in;
  logic [2:0][EXT_W-1:0] ext_in;

  assign pos_in = s_axis_tdata[POS_LSB +: AXIS_W];
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      axes_in[k] = s_axis_tdata[AXIS_LSB + k * AXIS_W +: AXIS_W];
      ext_in[k]  = s_axis_tdata[EXT_LSB + k * EXT_W +: EXT_W];
    end
  end

  // Item fields that travel alongside the lanes.
  op_e                   op_q  [3];
  logic [EXT_W-1:0]      rad_q [3];
  logic [2:0][EXT_W-1:0] ext_q [2];

  always_ff @(posedge clk_i) begin
    if (ctl.en[0]) begin
      op_q[0]  <= op_e'(s_axis_tuser);
      rad_q[0] <= s_axis_tdata[RAD_LSB +: EXT_W];
      ext_q[0] <= ext_in;
    end
    if (ctl.en[1]) begin
      op_q[1]  <= op_q[0];
      rad_q[1] <= rad_q[0];
      ext_q[1] <= ext_q[0];
    end
    if (ctl.en[2]) begin
      op_q[2]  <= op_q[1];
      rad_q[2] <= rad_q[1];
    end
  end

  // One lane per plane.
  logic [NUM_PLANES-1:0] reject;

  for (genvar i = 0; i < NUM_PLANES; i++) begin : g_lane
    fcc_lane u_lane (
      .clk_i    (clk_i),
      .ctl_i    (ctl),
      .plane_i  (plane_q[i]),
      .pos_i    (pos_in),
      .axes_i   (axes_in),
      .ext_i    (ext_q[1]),
      .rad_i    (rad_q[2]),
      .op_i     (op_q[2]),
      .reject_o (reject[i])
    );
  end

  // Output register: the object survives when no plane rejects it.
  logic visible_q;

  always_ff @(posedge clk_i) begin
    if (ctl.en[NUM_STAGES-1]) begin
      visible_q <= ~|reject;
    end
  end

  assign m_axis_tvalid = ctl.out_valid;
  assign m_axis_tdata  = TDATA_OUT_W'(visible_q);

endmodule
